FILE: rtl/readout_event_frame_decoder_defines.svh
// ------------------------------------------------------------------------
// Readout event frame decoder: assertion macros
// Shared property forms for the checks at the end of the top level.
// ------------------------------------------------------------------------
`ifndef READOUT_EVENT_FRAME_DECODER_DEFINES_SVH
`define READOUT_EVENT_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define REFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define REFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/refd_pkg.sv
// ------------------------------------------------------------------------
// Readout event frame decoder package
// Widths, code constants and the controller/datapath interface structs.
// ------------------------------------------------------------------------
package refd_pkg;

  localparam int unsigned NumChannelsDef  = 16;
  localparam int unsigned ScalerWindowDef = 10;

  localparam int unsigned WordW     = 32;
  localparam int unsigned ChanW     = 4;
  localparam int unsigned AdcW      = 12;
  localparam int unsigned TdcW      = 13;
  localparam int unsigned SumW      = 18;
  localparam int unsigned ScalW     = 14;
  localparam int unsigned LenW      = 12;
  localparam int unsigned TdataOutW = 128;

  localparam logic [6:0] ScalerClockCh = 7'd67;
  localparam logic [6:0] ScalerSnapCh  = 7'd68;

  // Commands from the controller
  typedef struct packed {
    logic hdr;
    logic data;
    logic err_rec;
    logic snap_clr;
    logic snap_step;
    logic emit_start;
    logic emit_step;
  } refd_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic is_hdr;
    logic len_zero;
    logic last_word;
    logic wl_zero;
    logic snap_hit;
    logic sweep_done;
    logic emit_last;
    logic out_free;
  } refd_sts_t;

endpackage

FILE: rtl/refd_datapath.sv
// ------------------------------------------------------------------------
// Readout event frame decoder datapath
// Word decode, per-frame channel stores, scaler snapshot ring with running
// window sums, and the registered output word.
// ------------------------------------------------------------------------
module refd_datapath
  import refd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS  = NumChannelsDef,
  parameter int unsigned SCALER_WINDOW = ScalerWindowDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WordW-1:0]     word_i,
  input  refd_cmd_t            cmd_i,
  output refd_sts_t            sts_o,
  output logic [TdataOutW-1:0] m_tdata_o,
  output logic                 m_tuser_o,
  output logic                 m_tlast_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i
);

  localparam int unsigned NSlots   = NUM_CHANNELS + 1;
  localparam int unsigned ChIdxW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned SlotIdxW = $clog2(NSlots);
  localparam int unsigned SlotW    = $clog2(NSlots + 1);
  localparam int unsigned PtrW     = (SCALER_WINDOW > 1) ? $clog2(SCALER_WINDOW) : 1;
  localparam int unsigned RingD    = SCALER_WINDOW * NSlots;
  localparam int unsigned RingAw   = $clog2(RingD);

  // Field decode
  logic              top_nz, adc_hi, adc_lo, tdc_ld, tdc_tr, scal;
  logic [5:0]        ch6;
  logic [6:0]        sch;
  logic              ch_ok, sch_ok, dec_en;
  logic [ChIdxW-1:0] ch_idx;

  assign top_nz = |word_i[31:24];
  assign ch6    = word_i[18:13];
  assign sch    = word_i[20:14];
  assign ch_ok  = (32'(ch6) < NUM_CHANNELS);
  assign sch_ok = (32'(sch) < NUM_CHANNELS);
  assign ch_idx = ch6[ChIdxW-1:0];
  assign adc_hi = (word_i[22:21] == 2'b00) && !word_i[19];
  assign adc_lo = (word_i[22:21] == 2'b00) && word_i[19];
  assign tdc_ld = (word_i[22:21] == 2'b01) && word_i[12];
  assign tdc_tr = (word_i[22:21] == 2'b01) && !word_i[12];
  assign scal   = (word_i[22:21] == 2'b10);

  logic            skip_q;
  logic [LenW-1:0] wl_q;
  assign dec_en = cmd_i.data && !skip_q && !top_nz;

  // Frame length and skip flag; frame end takes priority
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b0;
      wl_q   <= '0;
    end else if (cmd_i.emit_start) begin
      skip_q <= 1'b0;
      wl_q   <= '0;
    end else if (cmd_i.hdr) begin
      skip_q <= 1'b0;
      wl_q   <= word_i[LenW-1:0];
    end else if (cmd_i.data) begin
      wl_q <= wl_q - LenW'(1);
      if (!skip_q && top_nz) skip_q <= 1'b1;
    end
  end

  // Per-frame channel stores; an entry without its valid bit reads as no hit
  logic [AdcW-1:0] ah_q [NUM_CHANNELS];
  logic [AdcW-1:0] al_q [NUM_CHANNELS];
  logic [AdcW-1:0] ld_q [NUM_CHANNELS];
  logic [AdcW-1:0] tr_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ah_v_q, al_v_q, ld_v_q, tr_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ah_v_q <= '0;
      al_v_q <= '0;
      ld_v_q <= '0;
      tr_v_q <= '0;
    end else if (cmd_i.hdr) begin
      ah_v_q <= '0;
      al_v_q <= '0;
      ld_v_q <= '0;
      tr_v_q <= '0;
    end else if (dec_en && ch_ok) begin
      if (adc_hi && !word_i[12]) ah_v_q[ch_idx] <= 1'b1;
      else if (adc_lo && !word_i[12]) al_v_q[ch_idx] <= 1'b1;
      else if (tdc_ld) ld_v_q[ch_idx] <= 1'b1;
      else if (tdc_tr) tr_v_q[ch_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_en && ch_ok) begin
      if (adc_hi && !word_i[12]) ah_q[ch_idx] <= word_i[11:0];
      else if (adc_lo && !word_i[12]) al_q[ch_idx] <= word_i[11:0];
      else if (tdc_ld) ld_q[ch_idx] <= word_i[11:0];
      else if (tdc_tr) tr_q[ch_idx] <= word_i[11:0];
    end
  end

  // Latest scalers, clock in the top slot
  logic [ScalW-1:0] latest_q [NSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSlots; i++) latest_q[i] <= '0;
    end else if (dec_en && scal) begin
      if (sch_ok) latest_q[sch[SlotIdxW-1:0]] <= word_i[ScalW-1:0];
      else if (sch == ScalerClockCh) latest_q[SlotIdxW'(NUM_CHANNELS)] <= word_i[ScalW-1:0];
    end
  end

  // Event counter and ring pointer; the pointer restarts when the count wraps
  logic [WordW-1:0] evc_q, ev_q;
  logic [PtrW-1:0]  ptr_q;
  logic             sv_q;
  logic             ptr_wrap;
  logic             ev_wrap;

  assign ptr_wrap = (ptr_q == PtrW'(SCALER_WINDOW - 1));
  assign ev_wrap  = &evc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evc_q <= '0;
      ptr_q <= '0;
      ev_q  <= '0;
      sv_q  <= 1'b0;
    end else if (cmd_i.emit_start) begin
      ev_q  <= evc_q;
      evc_q <= evc_q + WordW'(1);
      sv_q  <= ptr_wrap || ev_wrap;
      ptr_q <= (ptr_wrap || ev_wrap) ? '0 : ptr_q + PtrW'(1);
    end
  end

  // Snapshot sweep: copy one slot a cycle into the ring row, update sums
  logic [SlotW-1:0]         k_q;
  logic [ScalW-1:0]         ring [RingD];
  logic [ScalW-1:0]         old_q, new_q;
  logic [SCALER_WINDOW-1:0] rowv_q;
  logic [SumW-1:0]          sums_q [NSlots];
  logic [RingAw-1:0]        ring_addr;
  logic                     k_live, sweep_done;
  logic [SumW-1:0]          old_ext;

  assign k_live     = (k_q < SlotW'(NSlots));
  assign sweep_done = (k_q == SlotW'(NSlots));
  assign ring_addr  = RingAw'(32'(ptr_q) * NSlots + 32'(k_q));
  assign old_ext    = rowv_q[ptr_q] ? SumW'(old_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.snap_clr) begin
      k_q <= '0;
    end else if (cmd_i.snap_step && k_live) begin
      k_q <= k_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap_step && k_live) begin
      old_q           <= ring[ring_addr];
      ring[ring_addr] <= latest_q[k_q[SlotIdxW-1:0]];
      new_q           <= latest_q[k_q[SlotIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowv_q <= '0;
      for (int i = 0; i < NSlots; i++) sums_q[i] <= '0;
    end else if (cmd_i.snap_step && (k_q != '0)) begin
      sums_q[SlotIdxW'(k_q - SlotW'(1))] <=
          sums_q[SlotIdxW'(k_q - SlotW'(1))] + SumW'(new_q) - old_ext;
      if (sweep_done) rowv_q[ptr_q] <= 1'b1;
    end
  end

  // Emit index
  logic [ChIdxW-1:0] e_q;
  logic              emit_last;
  assign emit_last = (e_q == ChIdxW'(NUM_CHANNELS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= '0;
    end else if (cmd_i.emit_start) begin
      e_q <= '0;
    end else if (cmd_i.emit_step) begin
      e_q <= e_q + ChIdxW'(1);
    end
  end

  // Output register
  logic                 ov_q, ou_q, ol_q;
  logic [TdataOutW-1:0] od_q;
  logic [TdataOutW-1:0] rec;
  logic [AdcW-1:0]      r_ah, r_al;
  logic [TdcW-1:0]      r_ld, r_tr;
  logic [SumW-1:0]      r_ss, r_cs;
  logic                 out_free;

  assign out_free = !ov_q || m_tready_i;

  always_comb begin
    r_ah = ah_v_q[e_q] ? ah_q[e_q] : '0;
    r_al = al_v_q[e_q] ? al_q[e_q] : '0;
    r_ld = ld_v_q[e_q] ? {1'b0, ld_q[e_q]} : '1;
    r_tr = tr_v_q[e_q] ? {1'b0, tr_q[e_q]} : '1;
    r_ss = sv_q ? sums_q[SlotIdxW'(e_q)] : '0;
    r_cs = sv_q ? sums_q[SlotIdxW'(NUM_CHANNELS)] : '0;
    rec  = {5'b0, ev_q, r_cs, sv_q, r_ss, r_tr, r_ld, r_al, r_ah, ChanW'(e_q)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit_step || cmd_i.err_rec) begin
      ov_q <= 1'b1;
    end else if (m_tready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      od_q <= rec;
      ou_q <= 1'b0;
      ol_q <= emit_last;
    end else if (cmd_i.err_rec) begin
      od_q <= {5'b0, evc_q, SumW'(0), 1'b0, SumW'(0), {TdcW{1'b1}}, {TdcW{1'b1}},
               AdcW'(0), AdcW'(0), ChanW'(0)};
      ou_q <= 1'b1;
      ol_q <= 1'b1;
    end
  end

  assign m_tdata_o  = od_q;
  assign m_tuser_o  = ou_q;
  assign m_tlast_o  = ol_q;
  assign m_tvalid_o = ov_q;

  // Status
  always_comb begin
    sts_o.is_hdr     = word_i[27];
    sts_o.len_zero   = (word_i[LenW-1:0] == '0);
    sts_o.last_word  = (wl_q == LenW'(1));
    sts_o.wl_zero    = (wl_q == '0);
    sts_o.snap_hit   = !skip_q && !top_nz && scal && (sch == ScalerSnapCh);
    sts_o.sweep_done = sweep_done;
    sts_o.emit_last  = emit_last;
    sts_o.out_free   = out_free;
  end

endmodule

FILE: rtl/refd_ctrl.sv
// ------------------------------------------------------------------------
// Readout event frame decoder controller
// Sequences header, data, snapshot sweep and record emission.
// ------------------------------------------------------------------------
module refd_ctrl
  import refd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  refd_sts_t sts_i,
  output refd_cmd_t cmd_o
);

  typedef enum logic [1:0] {ST_WAIT, ST_DATA, ST_SNAP, ST_EMIT} state_e;

  state_e state_q, state_d;
  logic   acc;

  // Ready: headers need room for a possible error word
  always_comb begin
    unique case (state_q)
      ST_WAIT: s_tready_o = sts_i.out_free;
      ST_DATA: s_tready_o = 1'b1;
      default: s_tready_o = 1'b0;
    endcase
  end

  assign acc = s_tvalid_i && s_tready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_WAIT: begin
        if (acc) begin
          if (sts_i.is_hdr) begin
            cmd_o.hdr = 1'b1;
            if (sts_i.len_zero) begin
              cmd_o.emit_start = 1'b1;
              state_d          = ST_EMIT;
            end else begin
              state_d = ST_DATA;
            end
          end else begin
            cmd_o.err_rec = 1'b1;
          end
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd_o.data = 1'b1;
          if (sts_i.snap_hit) begin
            cmd_o.snap_clr = 1'b1;
            state_d        = ST_SNAP;
          end else if (sts_i.last_word) begin
            cmd_o.emit_start = 1'b1;
            state_d          = ST_EMIT;
          end
        end
      end
      ST_SNAP: begin
        cmd_o.snap_step = 1'b1;
        if (sts_i.sweep_done) begin
          if (sts_i.wl_zero) begin
            cmd_o.emit_start = 1'b1;
            state_d          = ST_EMIT;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) state_d = ST_WAIT;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/readout_event_frame_decoder.sv
// Flow: the last word of a frame starts NUM_CHANNELS records, one per cycle
// while the output is free, each loaded from ST_EMIT into the output register.
// Throughput: header wait needs a free output; in a frame, one word per cycle,
// but a scaler snapshot word holds input off while the ring sweep runs.
// Reset: asynchronous active low; clears control, counters, scalers and sums.
// ------------------------------------------------------------------------
// Readout event frame decoder
// Decodes framed readout words and emits one record per channel per frame.
// ------------------------------------------------------------------------
`include "readout_event_frame_decoder_defines.svh"

module readout_event_frame_decoder
  import refd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS  = NumChannelsDef,
  parameter int unsigned SCALER_WINDOW = ScalerWindowDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [31:0] word
  input  logic [WordW-1:0]     s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [3:0] channel, [15:4] adc_high, [27:16] adc_low, [40:28] tdc_lead,
  // [53:41] tdc_trail, [71:54] scaler_sum, [72] scaler_valid,
  // [90:73] clock_sum, [122:91] event_number, [127:123] zero
  output logic [TdataOutW-1:0] m_axis_tdata_o,
  // [0] frame_error
  output logic                 m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  refd_cmd_t cmd;
  refd_sts_t sts;

  refd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  refd_datapath #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .SCALER_WINDOW (SCALER_WINDOW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .word_i     (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i)
  );

  // Checks
  `REFD_ASSERT_IMP(a_err_single, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o)
  `REFD_ASSERT_IMP(a_sweep_blocks, clk_i, rst_ni, cmd.snap_step, !s_axis_tready_o)
  `REFD_ASSERT_NXT(a_load_valid, clk_i, rst_ni, cmd.emit_step || cmd.err_rec, m_axis_tvalid_o)

endmodule
